/* src/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants and types for the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int TABLE_FRAMES      = 64;
	localparam int ENTRIES_PER_TABLE = 512;

	localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
	localparam int FRAME_W   = $clog2(TABLE_FRAMES);
	localparam int NF_W      = $clog2(TABLE_FRAMES + 1);
	localparam int ADDR_W    = FRAME_W + IDX_W;
	localparam int MEM_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;

	localparam int VA_W       = 64;
	localparam int VA_USED_W  = 48;
	localparam int PA_W       = 52;
	localparam int ENTRY_W    = 64;
	localparam int PAGE_SHIFT = 12;
	localparam int HUGE_SHIFT = 21;
	localparam int FLAGS_W    = 8;
	localparam int STATUS_W   = 3;

	localparam int PRESENT_BIT = 0;
	localparam int HUGE_BIT    = 7;

	localparam logic       MODE_TRANSLATE = 1'b0;
	localparam logic       MODE_MAP       = 1'b1;
	localparam logic [1:0] TABLE_FLAGS    = 2'b11;

	// Table levels, counted down as the walk descends.
	localparam logic [1:0] LVL_P4 = 2'd3;
	localparam logic [1:0] LVL_P3 = 2'd2;
	localparam logic [1:0] LVL_P2 = 2'd1;
	localparam logic [1:0] LVL_P1 = 2'd0;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NONCANON   = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_UNMAPPED   = 3'd3,
		ST_NOFRAME    = 3'd4
	} status_t;

endpackage

/* src/four_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks or builds a four-level page table held in an on-chip table memory.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | in_valid / in_ready | mode, vaddr, target_phys, entry_flags
//  result   | out_valid/out_ready | phys_out, status
//
// A request is accepted in S_IDLE, then the walk reads one table entry per
// level walked (no level is walked when the address or target is rejected),
// and S_DONE loads the result once the output register is free.
// A map also clears each table that it creates, one entry per cycle through
// the single write port, and then resumes the walk in the new frame.
// After reset the root table is cleared with in_ready low.
// One request is in flight at a time; a new one is taken while the previous
// result still waits in the output register.
//
module four_level_page_table_walker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [ptw_pkg::VA_W-1:0]         vaddr,
	input  logic [ptw_pkg::PA_W-1:0]         target_phys,
	input  logic [ptw_pkg::FLAGS_W-1:0]      entry_flags,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ptw_pkg::PA_W-1:0]         phys_out,
	output logic [ptw_pkg::STATUS_W-1:0]     status
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_RESUME,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACT_WAIT,
		ACT_DESCEND,
		ACT_CREATE,
		ACT_FINISH
	} act_t;

	function automatic logic [ptw_pkg::IDX_W-1:0] level_index(
		input logic [1:0]                      lvl,
		input logic [ptw_pkg::VA_USED_W-1:0]   va
	);
		return va[ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_W * lvl +: ptw_pkg::IDX_W];
	endfunction

	state_t                             state_q;
	logic                               walk_q;
	logic [ptw_pkg::IDX_W-1:0]          clr_idx_q;
	logic [ptw_pkg::NF_W-1:0]           nf_q;
	logic [ptw_pkg::FRAME_W-1:0]        frame_q;
	logic [1:0]                         lvl_q;
	logic                               mode_q;
	logic [ptw_pkg::VA_USED_W-1:0]      va_q;
	logic [ptw_pkg::PA_W-1:0]           target_q;
	logic [ptw_pkg::FLAGS_W-1:0]        flags_q;
	logic [ptw_pkg::PA_W-1:0]           res_phys_q;
	ptw_pkg::status_t                   res_status_q;
	logic                               out_valid_q;
	logic [ptw_pkg::PA_W-1:0]           phys_out_q;
	ptw_pkg::status_t                   status_q;

	logic                               rd_en;
	logic [ptw_pkg::ADDR_W-1:0]         rd_addr;
	logic [ptw_pkg::ENTRY_W-1:0]        rd_data;
	logic                               wr_en;
	logic [ptw_pkg::ADDR_W-1:0]         wr_addr;
	logic [ptw_pkg::ENTRY_W-1:0]        wr_data;

	act_t                               act;
	ptw_pkg::status_t                   fin_status;
	logic [ptw_pkg::PA_W-1:0]           fin_phys;

	logic [ptw_pkg::ENTRY_W-1:0]        entry;
	logic                               present;
	logic                               huge;
	logic [ptw_pkg::FRAME_W-1:0]        child;
	logic                               child_ok;
	logic                               nf_full;
	logic [ptw_pkg::ADDR_W-1:0]         cur_addr;
	logic [ptw_pkg::ENTRY_W-1:0]        leaf;
	logic [ptw_pkg::ENTRY_W-1:0]        ptr_entry;
	logic [ptw_pkg::PA_W-1:0]           huge_phys;
	logic [ptw_pkg::PA_W-1:0]           std_phys;
	logic                               in_noncanon;

	ptw_ram #(
		.WIDTH(ptw_pkg::ENTRY_W),
		.DEPTH(ptw_pkg::MEM_DEPTH)
	) u_table_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign entry    = rd_data;
	assign present  = entry[ptw_pkg::PRESENT_BIT];
	assign huge     = entry[ptw_pkg::HUGE_BIT];
	assign child    = entry[ptw_pkg::PAGE_SHIFT +: ptw_pkg::FRAME_W];
	// An entry points to a table only if its frame number is already allocated.
	assign child_ok = (entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT + ptw_pkg::FRAME_W] == '0)
		&& (ptw_pkg::NF_W'(child) < nf_q);
	assign nf_full  = (nf_q == ptw_pkg::NF_W'(ptw_pkg::TABLE_FRAMES));
	assign cur_addr = {frame_q, level_index(lvl_q, va_q)};

	assign leaf = {{(ptw_pkg::ENTRY_W - ptw_pkg::PA_W){1'b0}},
		target_q[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT],
		{(ptw_pkg::PAGE_SHIFT - ptw_pkg::FLAGS_W){1'b0}},
		flags_q[ptw_pkg::FLAGS_W-1:1], 1'b1};
	assign ptr_entry = ptw_pkg::ENTRY_W'({nf_q[ptw_pkg::FRAME_W-1:0],
		{(ptw_pkg::PAGE_SHIFT - 2){1'b0}}, ptw_pkg::TABLE_FLAGS});

	// A huge entry may carry address bits below 2 MiB, so this is a true add.
	assign huge_phys = {entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT],
		{ptw_pkg::PAGE_SHIFT{1'b0}}} + ptw_pkg::PA_W'(va_q[ptw_pkg::HUGE_SHIFT-1:0]);
	assign std_phys  = {entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT],
		va_q[ptw_pkg::PAGE_SHIFT-1:0]};

	assign in_noncanon = !((&vaddr[ptw_pkg::VA_W-1:ptw_pkg::VA_USED_W-1])
		|| (~|vaddr[ptw_pkg::VA_W-1:ptw_pkg::VA_USED_W-1]));

	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = cur_addr;
		wr_en      = 1'b0;
		wr_addr    = cur_addr;
		wr_data    = leaf;
		act        = ACT_WAIT;
		fin_status = ptw_pkg::ST_OK;
		fin_phys   = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = {frame_q, clr_idx_q};
				wr_data = '0;
			end
			S_IDLE: begin
				rd_en   = in_valid;
				rd_addr = {ptw_pkg::FRAME_W'(0),
					level_index(ptw_pkg::LVL_P4, vaddr[ptw_pkg::VA_USED_W-1:0])};
			end
			S_RESUME: begin
				rd_en = 1'b1;
			end
			S_LOOKUP: begin
				if (lvl_q == ptw_pkg::LVL_P1) begin
					act = ACT_FINISH;
					if (mode_q == ptw_pkg::MODE_MAP) begin
						wr_en = 1'b1;
					end else if (!present) begin
						fin_status = ptw_pkg::ST_UNMAPPED;
					end else begin
						fin_phys = std_phys;
					end
				end else if (mode_q == ptw_pkg::MODE_MAP && lvl_q == ptw_pkg::LVL_P2
						&& flags_q[ptw_pkg::HUGE_BIT]) begin
					act   = ACT_FINISH;
					wr_en = 1'b1;
				end else if (!present) begin
					if (mode_q == ptw_pkg::MODE_TRANSLATE) begin
						act        = ACT_FINISH;
						fin_status = ptw_pkg::ST_UNMAPPED;
					end else if (nf_full) begin
						act        = ACT_FINISH;
						fin_status = ptw_pkg::ST_NOFRAME;
					end else begin
						act     = ACT_CREATE;
						wr_en   = 1'b1;
						wr_data = ptr_entry;
					end
				end else if (huge) begin
					act = ACT_FINISH;
					if (mode_q == ptw_pkg::MODE_TRANSLATE && lvl_q == ptw_pkg::LVL_P2) begin
						fin_phys = huge_phys;
					end else begin
						fin_status = ptw_pkg::ST_UNMAPPED;
					end
				end else if (!child_ok) begin
					act        = ACT_FINISH;
					fin_status = ptw_pkg::ST_UNMAPPED;
				end else begin
					act     = ACT_DESCEND;
					rd_en   = 1'b1;
					rd_addr = {child, level_index(lvl_q - 2'd1, va_q)};
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			walk_q       <= 1'b0;
			clr_idx_q    <= '0;
			nf_q         <= ptw_pkg::NF_W'(1);
			frame_q      <= '0;
			lvl_q        <= ptw_pkg::LVL_P4;
			out_valid_q  <= 1'b0;
			res_status_q <= ptw_pkg::ST_OK;
			status_q     <= ptw_pkg::ST_OK;
		end else begin
			// In S_DONE the output register is handled below.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + ptw_pkg::IDX_W'(1);
					if (&clr_idx_q) begin
						state_q <= walk_q ? S_RESUME : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q     <= mode;
						va_q       <= vaddr[ptw_pkg::VA_USED_W-1:0];
						target_q   <= target_phys;
						flags_q    <= entry_flags;
						frame_q    <= '0;
						lvl_q      <= ptw_pkg::LVL_P4;
						walk_q     <= 1'b0;
						res_phys_q <= '0;
						if (in_noncanon) begin
							res_status_q <= ptw_pkg::ST_NONCANON;
							state_q      <= S_DONE;
						end else if (mode == ptw_pkg::MODE_MAP
								&& target_phys[ptw_pkg::PAGE_SHIFT-1:0] != '0) begin
							res_status_q <= ptw_pkg::ST_MISALIGNED;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					case (act)
						ACT_FINISH: begin
							res_status_q <= fin_status;
							res_phys_q   <= fin_phys;
							state_q      <= S_DONE;
						end
						ACT_DESCEND: begin
							frame_q <= child;
							lvl_q   <= lvl_q - 2'd1;
						end
						ACT_CREATE: begin
							// The new frame is cleared, then the walk reads on into it.
							frame_q   <= nf_q[ptw_pkg::FRAME_W-1:0];
							nf_q      <= nf_q + ptw_pkg::NF_W'(1);
							lvl_q     <= lvl_q - 2'd1;
							walk_q    <= 1'b1;
							clr_idx_q <= '0;
							state_q   <= S_CLEAR;
						end
						default: begin
						end
					endcase
				end
				S_RESUME: begin
					state_q <= S_LOOKUP;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						phys_out_q  <= res_phys_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign phys_out  = phys_out_q;
	assign status    = status_q;

	// A read and a write never meet on the same entry in one cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("table memory read and write collide on one entry");

	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q != '0) && (nf_q <= ptw_pkg::NF_W'(ptw_pkg::TABLE_FRAMES)))
		else $error("next free frame out of range");

	a_create_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP && act == ACT_CREATE)
		|=> (state_q == S_CLEAR && nf_q == $past(nf_q) + ptw_pkg::NF_W'(1)))
		else $error("table creation did not allocate and clear a frame");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ptw_pkg::ST_OK) |-> (phys_out_q == '0))
		else $error("error result carries a nonzero address");

endmodule

/* src/ptw_ram.sv */
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
